>>> rtl/orat_pkg.sv
// ----------------------------------------------------------------------------
// orat_pkg: shared types and constants of the rotary angle tracker
// Register indexes, widths of the shared divider and its request/response.
// ----------------------------------------------------------------------------
package orat_pkg;

	localparam int N_W     = 16;  // counts per turn
	localparam int POS_W   = 17;  // wrapped X position
	localparam int SUM_W   = 18;  // X position plus one delta
	localparam int DVD_W   = 25;  // p * 360 with p <= 65535
	localparam int QUO_W   = 9;   // angle quotient, at most 360
	localparam int CNT_W   = 5;
	localparam int DELTA_W = 12;
	localparam int ANGLE_W = 12;

	localparam logic [CNT_W-1:0] WRAP_STEPS  = CNT_W'(17);
	localparam logic [CNT_W-1:0] ANGLE_STEPS = CNT_W'(QUO_W);

	localparam logic [ANGLE_W-1:0] ANGLE_NONE = 12'hFFF;
	localparam logic [N_W-1:0]     N_RESET    = 16'd4096;

	typedef enum logic {
		REG_COUNTS_PER_TURN = 1'b0,
		REG_SENSOR_OK       = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic             start;
		logic [N_W-1:0]   divisor;
		logic [N_W-1:0]   rem_init;
		logic [DVD_W-1:0] dvd_init;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [N_W-1:0]   rem;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

>>> rtl/optical_rotary_angle_tracker_top.sv
// ----------------------------------------------------------------------------
// optical_rotary_angle_tracker_top: motion reports to wrapped X and angle
// Accumulates sensor deltas, wraps X by counts per turn, converts to degrees.
// ----------------------------------------------------------------------------
// channel  | handshake           | payload
// in       | in_valid/in_ready   | pin_level status_byte x/y_low_byte high_nibbles
// out      | out_valid/out_ready | delta_x delta_y position_x angle_deg angle_new
// cfg      | cfg_we              | cfg_index cfg_data
//
// A skipped report goes straight to the result; a read report runs check, a
// wrap division if X needs one, decide, and for a new angle a multiply and an
// angle division on the shared divider. in_ready is high only in the idle state.
// The output register frees the sequencer: the next request is accepted while
// a result waits. arst_n clears positions, control and sets counts to 4096.
// ----------------------------------------------------------------------------
module optical_rotary_angle_tracker_top import orat_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [N_W-1:0]            cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      pin_level,
	input  logic [7:0]                status_byte,
	input  logic [7:0]                x_low_byte,
	input  logic [7:0]                y_low_byte,
	input  logic [7:0]                high_nibbles,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DELTA_W-1:0] delta_x,
	output logic signed [DELTA_W-1:0] delta_y,
	output logic signed [POS_W-1:0]   position_x,
	output logic [ANGLE_W-1:0]        angle_deg,
	output logic                      angle_new
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CHECK  = 8'b0000_0010,
		S_WRAP   = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_MUL    = 8'b0001_0000,
		S_ASTART = 8'b0010_0000,
		S_ANGLE  = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [N_W-1:0]            counts_q;
	logic                      sensor_ok_q;
	logic signed [POS_W-1:0]   x_q;
	logic [31:0]               y_q;
	logic signed [POS_W-1:0]   last_x_q;
	logic signed [DELTA_W-1:0] dx_q;
	logic signed [DELTA_W-1:0] dy_q;
	logic signed [SUM_W-1:0]   s_q;
	logic                      neg_q;
	logic [N_W-1:0]            p_q;
	logic [DVD_W-1:0]          prod_q;
	logic [ANGLE_W-1:0]        angle_q;
	logic                      new_q;
	logic                      out_valid_q;

	logic [N_W-1:0]            n_eff;
	logic                      rd;
	logic signed [DELTA_W-1:0] dx_in;
	logic signed [DELTA_W-1:0] dy_in;
	logic signed [SUM_W-1:0]   n_s;
	logic                      wrap_hi;
	logic                      wrap_lo;
	logic signed [SUM_W-1:0]   s_neg;
	logic [POS_W-1:0]          mag;
	logic signed [POS_W-1:0]   x_plus_n;
	logic [DVD_W-1:0]          prod;
	logic                      out_free;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	assign n_eff = (counts_q == '0) ? N_W'(1) : counts_q;
	assign rd    = sensor_ok_q & ~pin_level;
	assign dx_in = (rd & status_byte[7]) ? {high_nibbles[7:4], x_low_byte} : '0;
	assign dy_in = (rd & status_byte[7]) ? {high_nibbles[3:0], y_low_byte} : '0;

	assign n_s     = $signed({2'b00, n_eff});
	assign wrap_hi = s_q >= n_s;
	assign wrap_lo = s_q <= -n_s;
	assign s_neg   = -s_q;
	assign mag     = wrap_hi ? s_q[POS_W-1:0] : s_neg[POS_W-1:0];

	assign x_plus_n = $signed({1'b0, n_eff}) + x_q;

	// p * 360 = p * (256 + 64 + 32 + 8)
	assign prod = {1'b0, p_q, 8'b0} + {3'b0, p_q, 6'b0} + {4'b0, p_q, 5'b0}
		+ {6'b0, p_q, 3'b0};

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		div_req          = '0;
		div_req.divisor  = n_eff;
		if (state_q == S_CHECK) begin
			div_req.start    = wrap_hi || wrap_lo;
			div_req.dvd_init = {mag, 8'b0};
			div_req.steps    = WRAP_STEPS;
		end else if (state_q == S_ASTART) begin
			// product < 512 * n, so the top bits already form a partial remainder
			div_req.start    = 1'b1;
			div_req.rem_init = prod_q[DVD_W-1:QUO_W];
			div_req.dvd_init = {prod_q[QUO_W-1:0], {(DVD_W-QUO_W){1'b0}}};
			div_req.steps    = ANGLE_STEPS;
		end
	end

	orat_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q    <= N_RESET;
			sensor_ok_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNTS_PER_TURN: counts_q    <= cfg_data;
				REG_SENSOR_OK:       sensor_ok_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			last_x_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a finished result, else drop the one taken by the receiver
			out_valid_q <= (state_q == S_FINISH && out_free) ? 1'b1
				: (out_valid_q && !out_ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						y_q     <= y_q + 32'(dy_in);
						state_q <= rd ? S_CHECK : S_FINISH;
					end
				end
				S_CHECK: begin
					if (wrap_hi || wrap_lo) begin
						state_q <= S_WRAP;
					end else begin
						x_q     <= s_q[POS_W-1:0];
						state_q <= S_DECIDE;
					end
				end
				S_WRAP: begin
					if (div_rsp.done) begin
						// keep the sign of the sum
						x_q     <= neg_q ? -$signed({1'b0, div_rsp.rem})
							: $signed({1'b0, div_rsp.rem});
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= (dx_q != '0 && x_q != last_x_q) ? S_MUL : S_FINISH;
				end
				S_MUL: state_q <= S_ASTART;
				S_ASTART: state_q <= S_ANGLE;
				S_ANGLE: begin
					if (div_rsp.done) begin
						last_x_q <= x_q;
						state_q  <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				dx_q    <= dx_in;
				dy_q    <= dy_in;
				s_q     <= {x_q[POS_W-1], x_q} + SUM_W'(dx_in);
				angle_q <= ANGLE_NONE;
				new_q   <= 1'b0;
			end
			S_CHECK: neg_q <= wrap_lo;
			S_DECIDE: p_q <= (x_q > 0) ? x_q[N_W-1:0] : x_plus_n[N_W-1:0];
			S_MUL: prod_q <= prod;
			S_ANGLE: begin
				if (div_rsp.done) begin
					angle_q <= ANGLE_W'(div_rsp.quo);
					new_q   <= 1'b1;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					delta_x    <= dx_q;
					delta_y    <= dy_q;
					position_x <= x_q;
					angle_deg  <= angle_q;
					angle_new  <= new_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/orat_div.sv
// ----------------------------------------------------------------------------
// orat_div: shared restoring divider
// One quotient bit per cycle; remainder and quotient valid with the done pulse.
// ----------------------------------------------------------------------------
module orat_div import orat_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [N_W-1:0]   rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [N_W-1:0]   divisor_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [N_W:0]     trial;
	logic             fits;
	logic [N_W:0]     diff;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CNT_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.rem_init;
			dvd_q     <= req.dvd_init;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[N_W-1:0] : trial[N_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quo  = dvd_q[QUO_W-1:0];

endmodule

>>> rtl/orat_checker.sv
// ----------------------------------------------------------------------------
// orat_checker: port-level checks of the rotary angle tracker
// Watches result consistency and the request sequencing on the top ports.
// ----------------------------------------------------------------------------
module orat_checker import orat_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [DELTA_W-1:0] delta_x,
	input logic signed [POS_W-1:0]   position_x,
	input logic [ANGLE_W-1:0]        angle_deg,
	input logic                      angle_new
);

	// one request at a time: drop ready right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready high right after an accepted request");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && angle_new |-> angle_deg <= ANGLE_W'(360))
		else $error("new angle above 360");

	a_angle_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !angle_new |-> angle_deg == ANGLE_NONE)
		else $error("no-angle result without marker");

	a_angle_needs_motion: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && delta_x == '0 |-> !angle_new)
		else $error("new angle without X motion");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(position_x))
		else $error("stalled result changed");

endmodule

bind optical_rotary_angle_tracker_top orat_checker u_orat_checker (.*);

>>> sim/angle_tracker_check.sv
// ----------------------------------------------------------------------------
// angle_tracker_check: prediction and checking for the rotary angle tracker
// Follows the register writes, models each accepted motion report and
// compares every accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module angle_tracker_check import orat_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [N_W-1:0]            cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      pin_level,
	input  logic [7:0]                status_byte,
	input  logic [7:0]                x_low_byte,
	input  logic [7:0]                y_low_byte,
	input  logic [7:0]                high_nibbles,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic signed [DELTA_W-1:0] delta_x,
	input  logic signed [DELTA_W-1:0] delta_y,
	input  logic signed [POS_W-1:0]   position_x,
	input  logic [ANGLE_W-1:0]        angle_deg,
	input  logic                      angle_new,
	output int                        fail_count,
	output int                        outstanding,
	output int                        reports_checked,
	output int                        angles_checked
);

	localparam int DEG_PER_TURN = 360;

	typedef struct packed {
		logic       pin;
		logic [7:0] status;
		logic [7:0] x_lo;
		logic [7:0] y_lo;
		logic [7:0] hi;
	} report_t;

	typedef struct packed {
		logic signed [DELTA_W-1:0] dx;
		logic signed [DELTA_W-1:0] dy;
		logic signed [POS_W-1:0]   pos;
		logic [ANGLE_W-1:0]        angle;
		logic                      fresh;
	} angle_result_t;

	logic [N_W-1:0] turn_counts;
	logic           sensor_usable;
	int             x_pos;
	logic [31:0]    y_pos;
	int             last_x;
	int             errs;
	int             n_checked;
	int             n_fresh;
	angle_result_t  pending_angles[$];

	function automatic angle_result_t track_report(input report_t r);
		angle_result_t             res;
		logic signed [DELTA_W-1:0] dx12;
		logic signed [DELTA_W-1:0] dy12;
		int                        dx;
		int                        dy;
		int                        n;
		int                        s;
		int                        p;
		res.dx = '0;
		res.dy = '0;
		res.angle = ANGLE_NONE;
		res.fresh = 1'b0;
		n = (turn_counts == '0) ? 1 : int'(turn_counts);
		if (sensor_usable && !r.pin) begin
			dx = 0;
			dy = 0;
			if (r.status[7]) begin
				dx12 = {r.hi[7:4], r.x_lo};
				dy12 = {r.hi[3:0], r.y_lo};
				dx = dx12;
				dy = dy12;
			end
			// wrap by a full remainder, keeping the sign of the sum
			s = x_pos + dx;
			if (s >= n)
				s = s % n;
			else if (s <= -n)
				s = -((-s) % n);
			x_pos = s;
			y_pos = y_pos + 32'(dy);
			if (dx != 0 && x_pos != last_x) begin
				p = (x_pos > 0) ? x_pos : n + x_pos;
				res.angle = ANGLE_W'(p * DEG_PER_TURN / n);
				res.fresh = 1'b1;
				last_x = x_pos;
			end
			res.dx = DELTA_W'(dx);
			res.dy = DELTA_W'(dy);
		end
		res.pos = POS_W'(x_pos);
		return res;
	endfunction

	function automatic void check_field(input string name, input logic signed [31:0] want_v,
			input logic signed [31:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t       rep;
		angle_result_t want;
		if (!arst_n) begin
			turn_counts = N_RESET;
			sensor_usable = 1'b0;
			x_pos = 0;
			y_pos = '0;
			last_x = 0;
			errs = 0;
			n_checked = 0;
			n_fresh = 0;
			pending_angles.delete();
			fail_count <= 0;
			outstanding <= 0;
			reports_checked <= 0;
			angles_checked <= 0;
		end else begin
			// retire the oldest prediction first: it is older than any request taken now
			if (out_valid && out_ready) begin
				if (pending_angles.size() == 0) begin
					$display("%0t: result with no request pending, %s %0d dy %0d x %0d angle %0d",
						$time, "expected none, got dx", delta_x, delta_y, position_x,
						angle_deg);
					errs++;
				end else begin
					want = pending_angles.pop_front();
					check_field("delta_x", want.dx, delta_x);
					check_field("delta_y", want.dy, delta_y);
					check_field("position_x", want.pos, position_x);
					check_field("angle_deg", want.angle, angle_deg);
					check_field("angle_new", want.fresh, angle_new);
					n_checked++;
					if (want.fresh)
						n_fresh++;
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_COUNTS_PER_TURN: turn_counts = cfg_data;
					REG_SENSOR_OK:       sensor_usable = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				rep.pin = pin_level;
				rep.status = status_byte;
				rep.x_lo = x_low_byte;
				rep.y_lo = y_low_byte;
				rep.hi = high_nibbles;
				pending_angles.push_back(track_report(rep));
			end
			fail_count <= errs;
			outstanding <= pending_angles.size();
			reports_checked <= n_checked;
			angles_checked <= n_fresh;
		end
	end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the optical rotary angle tracker
// Drives directed and random motion reports through several register
// settings with random gaps on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
	import orat_pkg::*;

	localparam int  SETTLE_CYCLES = 40;
	localparam int  STALL_CYCLES  = 400;
	localparam int  RAND_PHASES   = 9;
	localparam int  PHASE_ITEMS   = 140;
	localparam int  DARK_ITEMS    = 40;
	localparam time WATCHDOG      = 64'd10_000_000;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic                      cfg_index;
	logic [N_W-1:0]            cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      pin_level;
	logic [7:0]                status_byte;
	logic [7:0]                x_low_byte;
	logic [7:0]                y_low_byte;
	logic [7:0]                high_nibbles;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic signed [POS_W-1:0]   position_x;
	logic [ANGLE_W-1:0]        angle_deg;
	logic                      angle_new;

	int fail_count;
	int outstanding;
	int reports_checked;
	int angles_checked;
	int reg_writes;
	bit no_idle;
	bit stall_req;

	optical_rotary_angle_tracker_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pin_level     (pin_level),
		.status_byte   (status_byte),
		.x_low_byte    (x_low_byte),
		.y_low_byte    (y_low_byte),
		.high_nibbles  (high_nibbles),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.position_x    (position_x),
		.angle_deg     (angle_deg),
		.angle_new     (angle_new)
	);

	angle_tracker_check check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.pin_level       (pin_level),
		.status_byte     (status_byte),
		.x_low_byte      (x_low_byte),
		.y_low_byte      (y_low_byte),
		.high_nibbles    (high_nibbles),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.delta_x         (delta_x),
		.delta_y         (delta_y),
		.position_x      (position_x),
		.angle_deg       (angle_deg),
		.angle_new       (angle_new),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.reports_checked (reports_checked),
		.angles_checked  (angles_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [DELTA_W-1:0] pick_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return DELTA_W'($urandom_range(0, 48)) - DELTA_W'(24);
		if (r < 75)
			return DELTA_W'($urandom);
		case ($urandom_range(0, 3))
			0: return 12'h7FF;
			1: return 12'h800;
			2: return 12'h000;
			default: return 12'hFFF;
		endcase
	endfunction

	// hold the request until accepted; a back-to-back request keeps valid high
	task automatic send_report(input logic pin, input logic [7:0] status,
			input logic [DELTA_W-1:0] dx, input logic [DELTA_W-1:0] dy);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pin_level <= pin;
		status_byte <= status;
		x_low_byte <= dx[7:0];
		y_low_byte <= dy[7:0];
		high_nibbles <= {dx[11:8], dy[11:8]};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic [7:0] status;
		status = 8'($urandom);
		status[7] = ($urandom_range(0, 99) < 85);
		send_report($urandom_range(0, 99) < 12, status, pick_delta(), pick_delta());
	endtask

	// drop valid and wait until every predicted result has come out
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [N_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// receiver: one decision per cycle, long hold-off on request
	initial begin
		int hold_left;
		int g;
		out_ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_req) begin
				stall_req = 1'b0;
				hold_left = STALL_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 20) begin
				g = pick_gap();
				if (g > 0) begin
					hold_left = g - 1;
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(WATCHDOG);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [N_W-1:0] turns;
		logic           usable;
		int             items;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		pin_level = 1'b0;
		status_byte = '0;
		x_low_byte = '0;
		y_low_byte = '0;
		high_nibbles = '0;
		no_idle = 1'b0;
		stall_req = 1'b0;
		reg_writes = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: sensor not usable, nothing is read
		send_report(1'b0, 8'h80, 12'd100, 12'd5);
		send_report(1'b1, 8'hFF, 12'hFFF, 12'hFFF);
		settle();
		write_reg(REG_SENSOR_OK, 16'd1);

		// counts still at reset: skip, invalid status, extremes, land on zero, wrap
		send_report(1'b1, 8'h80, 12'd50, 12'd50);
		send_report(1'b0, 8'h7F, 12'd300, 12'd7);
		send_report(1'b0, 8'h80, 12'h7FF, 12'h800);
		send_report(1'b0, 8'h80, 12'h800, 12'h7FF);
		send_report(1'b0, 8'h80, 12'h001, 12'h000);
		send_report(1'b0, 8'hFF, 12'h000, 12'h000);
		send_report(1'b0, 8'h80, 12'h7FF, 12'h001);
		send_report(1'b0, 8'h80, 12'h7FF, 12'hFFF);
		send_report(1'b0, 8'h80, 12'h7FF, 12'h000);
		settle();

		// tiny turn: far sums wrap, a move back onto the last reported X
		write_reg(REG_COUNTS_PER_TURN, 16'd3);
		send_report(1'b0, 8'h80, 12'h001, 12'h000);
		send_report(1'b0, 8'h80, 12'h003, 12'h000);
		send_report(1'b0, 8'h80, 12'hFFF, 12'h000);
		send_report(1'b0, 8'h80, 12'h800, 12'h000);
		settle();
		write_reg(REG_COUNTS_PER_TURN, 16'd1);
		send_report(1'b0, 8'h80, 12'h005, 12'h000);
		send_report(1'b0, 8'h80, 12'h800, 12'h000);
		settle();
		// zero counts behaves as one
		write_reg(REG_COUNTS_PER_TURN, 16'd0);
		send_report(1'b0, 8'h80, 12'h7FF, 12'h000);
		settle();
		write_reg(REG_COUNTS_PER_TURN, 16'hFFFF);
		send_report(1'b0, 8'h80, 12'h7FF, 12'h7FF);
		send_report(1'b0, 8'h80, 12'h800, 12'h800);
		settle();
		write_reg(REG_SENSOR_OK, 16'd0);
		send_report(1'b0, 8'h80, 12'h123, 12'h456);
		settle();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			usable = 1'b1;
			items = PHASE_ITEMS;
			case (ph)
				0: turns = 16'hFFFF;
				1: turns = 16'd1;
				2: turns = N_W'($urandom_range(2, 12));
				3: turns = 16'd360;
				4: turns = 16'd4096;
				5: turns = N_W'($urandom_range(1, 65535));
				6: begin
					turns = 16'd2048;
					usable = 1'b0;
					items = DARK_ITEMS;
				end
				7: turns = 16'd0;
				default: turns = N_W'($urandom_range(13, 3000));
			endcase
			write_reg(REG_COUNTS_PER_TURN, turns);
			write_reg(REG_SENSOR_OK, N_W'(usable));
			no_idle = (ph == 4);
			// starve the output so the block fills up and backs up the input
			if (ph == 3)
				stall_req = 1'b1;
			for (int i = 0; i < items; i++)
				send_random();
			settle();
			no_idle = 1'b0;
		end

		$display("Checked %0d motion reports, %0d with a fresh angle, over %0d register writes.",
			reports_checked, angles_checked, reg_writes);
		$display("Covered skipped reads, invalid status, wraps, zero and tiny turns, long stall.");
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> optical_rotary_angle_tracker_top.f
rtl/orat_pkg.sv
rtl/orat_div.sv
rtl/optical_rotary_angle_tracker_top.sv
rtl/orat_checker.sv
sim/angle_tracker_check.sv
sim/tb_top.sv
